// ----- sv/polygon_boundary_point_insert_defines.svh -----
// assertion macros for the boundary polygon point store
// used by polygon_boundary_point_insert.sv, no other dependencies
`ifndef POLYGON_BOUNDARY_POINT_INSERT_DEFINES_SVH
`define POLYGON_BOUNDARY_POINT_INSERT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PBPI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PBPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pbpi_pkg.sv -----
// shared constants and types for the boundary polygon point store
// no dependencies
package pbpi_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int PT_W       = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int PT_SH      = 16 - PT_W;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ENTRY_W    = 96;

    localparam int MUL_A_W = 37;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = 55;
    localparam int ACC_W   = 58;
    localparam int QUO_W   = 18;
    localparam int REM_W   = 56;
    localparam int DIST_W  = 40;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_MOVE   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_LD3,
        S_LD,
        S_CR,
        S_TRI,
        S_NUM,
        S_DEN,
        S_X,
        S_DIV,
        S_DIST,
        S_CMP,
        S_TAN,
        S_V,
        S_VN,
        S_SIDE,
        S_NEXT,
        S_SHIFT,
        S_SHW,
        S_REM,
        S_REMW,
        S_DONE
    } t_state;

endpackage

// ----- sv/polygon_boundary_point_insert.sv -----
// boundary polygon point store: insert, move and remove of points with normals
// depends on pbpi_pkg and polygon_boundary_point_insert_defines.svh
//
// usage
// - slave channel s_*: one word per command; s_tuser is the operation
//   (insert, move, remove), s_tdata the slot index, point and normal
// - master channel m_*: one word per command with the placed slot, the
//   point total after the command and, in m_tuser, the error flag
// - points and normals sit in one 96-bit synchronous memory, one entry per
//   slot, a single shared 37x18 multiplier and a radix-2 divider do all
//   arithmetic
// - move and a refused command go straight to the result; remove shifts every
//   later slot down; the first two inserts are placed directly, the third
//   in slot 1 or 2 by orientation
// - later inserts scan every edge: a clamped projection needs no division,
//   an interior one three, a distance tie adds a side test, then the slots
//   above the chosen slot are shifted up
// - s_tready is high only while no command is in progress
// - a finished word waits in the output register; a stalled receiver holds
//   it and the block accepts the next command meanwhile, but the following
//   result waits until the register empties
// - reset clears the point total and the output valid; memory contents are
//   not cleared, only slots below the total are ever used
module polygon_boundary_point_insert (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot_index[5:0], point_x, point_y, point_z, normal_x, normal_y, normal_z, zero pad
    input  logic [103:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // placed_slot[5:0], point_total[12:6], zero pad
    output logic [15:0]  m_tdata,
    // error_flag[0]
    output logic [0:0]   m_tuser
);

    localparam int AW = pbpi_pkg::ADDR_W;
    localparam int CW = pbpi_pkg::CNT_W;
    localparam int EW = pbpi_pkg::ENTRY_W;

    pbpi_pkg::t_state r_state, n_state;

    logic [EW-1:0] r_mem [pbpi_pkg::MAX_POINTS];
    logic [EW-1:0] r_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] wr_data;
    logic          mem_we;

    pbpi_pkg::t_op     r_op;
    logic [5:0]        r_idx;
    logic signed [15:0] r_p [3];
    logic signed [15:0] r_n [3];
    logic signed [15:0] r_ph [3];
    logic signed [15:0] r_pi [3];
    logic signed [15:0] r_pj [3];
    logic signed [15:0] r_ni [3];
    logic signed [15:0] r_nj [3];
    logic signed [15:0] r_c [3];

    logic [CW-1:0] r_total, r_i, r_best, r_pos, r_ptr;
    logic [1:0]    r_step, r_k;
    logic [4:0]    r_dcnt;

    logic signed [pbpi_pkg::ACC_W-1:0]  r_acc;
    logic signed [pbpi_pkg::PROD_W-1:0] r_prod;
    logic                               r_prod_neg;
    logic signed [36:0]                 r_num;
    logic [35:0]                        r_den;
    logic signed [35:0]                 r_t [3];
    logic signed [35:0]                 r_v [3];
    logic [pbpi_pkg::DIST_W-1:0]        r_dist, r_min;
    logic                               r_vneg, r_xneg, r_err;
    logic [pbpi_pkg::REM_W-1:0]         r_rem, r_dsh;
    logic [pbpi_pkg::QUO_W-1:0]         r_q;

    logic       r_ov, r_o_err;
    logic [5:0] r_o_placed;
    logic [6:0] r_o_total;

    logic signed [15:0] in_p [3];
    logic signed [15:0] in_n [3];
    logic [15:0]        in_sh [3];
    logic [EW-1:0]      new_entry;

    logic signed [16:0] d [3];
    logic signed [16:0] w [3];
    logic signed [16:0] prev [3];
    logic signed [16:0] nsum [3];
    logic signed [16:0] off [3];

    logic signed [pbpi_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pbpi_pkg::MUL_B_W-1:0] mul_b;
    logic                                mul_neg;
    logic [1:0]                          mac_cnt, s_sel, k1, k2;
    logic                                mac_last;
    logic signed [pbpi_pkg::ACC_W-1:0]   acc_base, prod_ext, acc_sum, den_x2, n_mag;

    logic [CW-1:0] j_idx, h_idx;
    logic [15:0]   idx_w, total_w, pos_w;
    logic          idx_ok, full, div_ge, div_last, tie_win, clamp_a, clamp_b;
    logic [pbpi_pkg::QUO_W-1:0] q_fin;
    logic signed [18:0]         q_sgn;
    logic signed [18:0]         c_sum;

    function automatic logic [1:0] nxt(input logic [1:0] k);
        nxt = (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

    // memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // input unpack and packed entry
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_sh[k] = s_tdata[6 + 16*k +: 16] << pbpi_pkg::PT_SH;
            in_p[k]  = $signed(in_sh[k]) >>> pbpi_pkg::PT_SH;
            in_n[k]  = $signed(s_tdata[54 + 16*k +: 16]);
        end
        new_entry = {r_n[2], r_n[1], r_n[0], r_p[2], r_p[1], r_p[0]};
    end

    // edge vectors
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d[k]    = 17'(r_pj[k]) - 17'(r_pi[k]);
            w[k]    = 17'(r_p[k]) - 17'(r_pi[k]);
            prev[k] = 17'(r_pi[k]) - 17'(r_ph[k]);
            nsum[k] = 17'(r_nj[k]) + 17'(r_ni[k]);
            off[k]  = 17'(r_p[k]) - 17'(r_c[k]);
        end
    end

    // indexes and checks
    always_comb begin
        j_idx   = (r_i + CW'(1) == r_total) ? CW'(0) : r_i + CW'(1);
        h_idx   = (r_i == CW'(0)) ? r_total - CW'(1) : r_i - CW'(1);
        idx_w   = 16'(r_idx);
        total_w = 16'(r_total);
        pos_w   = 16'(r_pos);
        idx_ok  = idx_w < total_w;
        full    = total_w >= 16'(pbpi_pkg::MAX_POINTS);
    end

    // multiply-accumulate operand select
    always_comb begin
        s_sel   = (r_step == 2'd3) ? 2'd0 : r_step;
        k1      = nxt(r_k);
        k2      = nxt(k1);
        mac_cnt = 2'd3;
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (r_state)
            pbpi_pkg::S_CR: begin
                mac_cnt = 2'd2;
                mul_a   = (r_step == 2'd0) ? 37'(d[k1]) : 37'(d[k2]);
                mul_b   = (r_step == 2'd0) ? 18'(w[k2]) : 18'(w[k1]);
                mul_neg = (r_step != 2'd0);
            end
            pbpi_pkg::S_TAN: begin
                mac_cnt = 2'd2;
                mul_a   = (r_step == 2'd0) ? 37'(d[k1]) : 37'(d[k2]);
                mul_b   = (r_step == 2'd0) ? 18'(nsum[k2]) : 18'(nsum[k1]);
                mul_neg = (r_step != 2'd0);
            end
            pbpi_pkg::S_V: begin
                mac_cnt = 2'd2;
                mul_a   = (r_step == 2'd0) ? 37'(d[k1]) : 37'(d[k2]);
                mul_b   = (r_step == 2'd0) ? 18'(prev[k2]) : 18'(prev[k1]);
                mul_neg = (r_step != 2'd0);
            end
            pbpi_pkg::S_TRI: begin
                mul_a = 37'(r_t[s_sel]);
                mul_b = 18'(nsum[s_sel]);
            end
            pbpi_pkg::S_NUM: begin
                mul_a = 37'(w[s_sel]);
                mul_b = 18'(d[s_sel]);
            end
            pbpi_pkg::S_DEN: begin
                mul_a = 37'(d[s_sel]);
                mul_b = 18'(d[s_sel]);
            end
            pbpi_pkg::S_X: begin
                mac_cnt = 2'd1;
                mul_a   = r_num;
                mul_b   = 18'(d[r_k]);
            end
            pbpi_pkg::S_DIST: begin
                mul_a = 37'(off[s_sel]);
                mul_b = 18'(off[s_sel]);
            end
            pbpi_pkg::S_VN: begin
                mul_a = 37'(r_v[s_sel]);
                mul_b = 18'(r_ni[s_sel]);
            end
            pbpi_pkg::S_SIDE: begin
                mul_a = 37'(r_t[s_sel]);
                mul_b = 18'(off[s_sel]);
            end
            default: begin
                mac_cnt = 2'd3;
            end
        endcase
        mac_last = (r_step == mac_cnt);

        if (r_step == 2'd0) begin
            acc_base = (r_state == pbpi_pkg::S_X) ? $signed(58'(r_den)) : '0;
        end else begin
            acc_base = r_acc;
        end
        prod_ext = 58'(r_prod);
        if (r_state == pbpi_pkg::S_X) begin
            prod_ext = prod_ext <<< 1;
        end
        if (r_step == 2'd0) begin
            acc_sum = acc_base;
        end else begin
            acc_sum = r_prod_neg ? acc_base - prod_ext : acc_base + prod_ext;
        end

        clamp_a  = (acc_sum == '0) || (r_num <= 37'sd0);
        clamp_b  = 58'(r_num) >= acc_sum;
        den_x2   = $signed(58'({r_den, 1'b0}));
        n_mag    = acc_sum[57] ? den_x2 - 58'sd1 - acc_sum : acc_sum;
        div_ge   = r_rem >= r_dsh;
        div_last = (r_dcnt == 5'(pbpi_pkg::QUO_W - 1));
        q_fin    = {r_q[pbpi_pkg::QUO_W-2:0], div_ge};
        q_sgn    = r_xneg ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
        c_sum    = 19'(r_pi[r_k]) + q_sgn;
        tie_win  = r_vneg ? (acc_sum > 58'sd0) : (acc_sum < 58'sd0);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pbpi_pkg::S_IDLE: begin
                if (s_tvalid) n_state = pbpi_pkg::S_DISPATCH;
            end
            pbpi_pkg::S_DISPATCH: begin
                case (r_op)
                    pbpi_pkg::OP_INSERT: begin
                        if (full) n_state = pbpi_pkg::S_DONE;
                        else if (total_w < 16'd2) n_state = pbpi_pkg::S_SHIFT;
                        else if (total_w == 16'd2) n_state = pbpi_pkg::S_LD3;
                        else n_state = pbpi_pkg::S_LD;
                    end
                    pbpi_pkg::OP_REMOVE: begin
                        n_state = idx_ok ? pbpi_pkg::S_REM : pbpi_pkg::S_DONE;
                    end
                    default: n_state = pbpi_pkg::S_DONE;
                endcase
            end
            pbpi_pkg::S_LD3: begin
                if (r_step == 2'd2) n_state = pbpi_pkg::S_CR;
            end
            pbpi_pkg::S_LD: begin
                if (r_step == 2'd3) n_state = pbpi_pkg::S_NUM;
            end
            pbpi_pkg::S_CR: begin
                if (mac_last && r_k == 2'd2) n_state = pbpi_pkg::S_TRI;
            end
            pbpi_pkg::S_TRI: begin
                if (mac_last) n_state = pbpi_pkg::S_SHIFT;
            end
            pbpi_pkg::S_NUM: begin
                if (mac_last) n_state = pbpi_pkg::S_DEN;
            end
            pbpi_pkg::S_DEN: begin
                if (mac_last) begin
                    n_state = (clamp_a || clamp_b) ? pbpi_pkg::S_DIST : pbpi_pkg::S_X;
                end
            end
            pbpi_pkg::S_X: begin
                if (mac_last) n_state = pbpi_pkg::S_DIV;
            end
            pbpi_pkg::S_DIV: begin
                if (div_last) n_state = (r_k == 2'd2) ? pbpi_pkg::S_DIST : pbpi_pkg::S_X;
            end
            pbpi_pkg::S_DIST: begin
                if (mac_last) n_state = pbpi_pkg::S_CMP;
            end
            pbpi_pkg::S_CMP: begin
                if (r_i != CW'(0) && r_dist == r_min) n_state = pbpi_pkg::S_TAN;
                else n_state = pbpi_pkg::S_NEXT;
            end
            pbpi_pkg::S_TAN: begin
                if (mac_last && r_k == 2'd2) n_state = pbpi_pkg::S_V;
            end
            pbpi_pkg::S_V: begin
                if (mac_last && r_k == 2'd2) n_state = pbpi_pkg::S_VN;
            end
            pbpi_pkg::S_VN: begin
                if (mac_last) n_state = pbpi_pkg::S_SIDE;
            end
            pbpi_pkg::S_SIDE: begin
                if (mac_last) n_state = pbpi_pkg::S_NEXT;
            end
            pbpi_pkg::S_NEXT: begin
                n_state = (r_i + CW'(1) < r_total) ? pbpi_pkg::S_LD : pbpi_pkg::S_SHIFT;
            end
            pbpi_pkg::S_SHIFT: begin
                n_state = (r_ptr > r_pos) ? pbpi_pkg::S_SHW : pbpi_pkg::S_DONE;
            end
            pbpi_pkg::S_SHW: n_state = pbpi_pkg::S_SHIFT;
            pbpi_pkg::S_REM: begin
                n_state = (r_ptr + CW'(1) < r_total) ? pbpi_pkg::S_REMW : pbpi_pkg::S_DONE;
            end
            pbpi_pkg::S_REMW: n_state = pbpi_pkg::S_REM;
            pbpi_pkg::S_DONE: begin
                if (!r_ov || m_tready) n_state = pbpi_pkg::S_IDLE;
            end
            default: n_state = pbpi_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready = (r_state == pbpi_pkg::S_IDLE);
        rd_addr  = '0;
        wr_addr  = '0;
        wr_data  = r_rd;
        mem_we   = 1'b0;
        case (r_state)
            pbpi_pkg::S_LD: begin
                case (r_step)
                    2'd0:    rd_addr = h_idx[AW-1:0];
                    2'd1:    rd_addr = r_i[AW-1:0];
                    default: rd_addr = j_idx[AW-1:0];
                endcase
            end
            pbpi_pkg::S_LD3: begin
                rd_addr = (r_step == 2'd0) ? AW'(0) : AW'(1);
            end
            pbpi_pkg::S_DISPATCH: begin
                wr_addr = AW'(r_idx);
                wr_data = new_entry;
                mem_we  = (r_op == pbpi_pkg::OP_MOVE) && idx_ok;
            end
            pbpi_pkg::S_SHIFT: begin
                rd_addr = AW'(r_ptr - CW'(1));
                wr_addr = r_pos[AW-1:0];
                wr_data = new_entry;
                mem_we  = !(r_ptr > r_pos);
            end
            pbpi_pkg::S_SHW: begin
                wr_addr = r_ptr[AW-1:0];
                mem_we  = 1'b1;
            end
            pbpi_pkg::S_REM: begin
                rd_addr = AW'(r_ptr + CW'(1));
            end
            pbpi_pkg::S_REMW: begin
                wr_addr = r_ptr[AW-1:0];
                mem_we  = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbpi_pkg::S_IDLE;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pbpi_pkg::S_SHIFT && !(r_ptr > r_pos)) begin
                r_total <= r_total + CW'(1);
            end
            if (r_state == pbpi_pkg::S_REM && !(r_ptr + CW'(1) < r_total)) begin
                r_total <= r_total - CW'(1);
            end
            if (r_state == pbpi_pkg::S_DONE && (!r_ov || m_tready)) begin
                r_ov <= 1'b1;
            end else if (m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod     <= mul_a * mul_b;
        r_prod_neg <= mul_neg;
        case (r_state)
            pbpi_pkg::S_IDLE: begin
                r_op  <= pbpi_pkg::t_op'(s_tuser);
                r_idx <= s_tdata[5:0];
                for (int k = 0; k < 3; k++) begin
                    r_p[k] <= in_p[k];
                    r_n[k] <= in_n[k];
                end
            end
            pbpi_pkg::S_DISPATCH: begin
                r_step <= '0;
                r_i    <= '0;
                r_k    <= '0;
                r_pos  <= r_total;
                r_ptr  <= (r_op == pbpi_pkg::OP_REMOVE) ? CW'(r_idx) : r_total;
                case (r_op)
                    pbpi_pkg::OP_INSERT: r_err <= full;
                    pbpi_pkg::OP_MOVE:   r_err <= !idx_ok;
                    pbpi_pkg::OP_REMOVE: r_err <= !idx_ok;
                    default:             r_err <= 1'b1;
                endcase
            end
            pbpi_pkg::S_LD3: begin
                r_step <= (r_step == 2'd2) ? 2'd0 : r_step + 2'd1;
                for (int k = 0; k < 3; k++) begin
                    if (r_step == 2'd1) begin
                        r_pi[k] <= $signed(r_rd[16*k +: 16]);
                        r_ni[k] <= $signed(r_rd[48 + 16*k +: 16]);
                    end
                    if (r_step == 2'd2) begin
                        r_pj[k] <= $signed(r_rd[16*k +: 16]);
                        r_nj[k] <= $signed(r_rd[48 + 16*k +: 16]);
                    end
                end
            end
            pbpi_pkg::S_LD: begin
                r_step <= r_step + 2'd1;
                for (int k = 0; k < 3; k++) begin
                    if (r_step == 2'd1) begin
                        r_ph[k] <= $signed(r_rd[16*k +: 16]);
                    end
                    if (r_step == 2'd2) begin
                        r_pi[k] <= $signed(r_rd[16*k +: 16]);
                        r_ni[k] <= $signed(r_rd[48 + 16*k +: 16]);
                    end
                    if (r_step == 2'd3) begin
                        r_pj[k] <= $signed(r_rd[16*k +: 16]);
                        r_nj[k] <= $signed(r_rd[48 + 16*k +: 16]);
                    end
                end
            end
            pbpi_pkg::S_CR, pbpi_pkg::S_TAN, pbpi_pkg::S_V, pbpi_pkg::S_TRI,
            pbpi_pkg::S_NUM, pbpi_pkg::S_DEN, pbpi_pkg::S_X, pbpi_pkg::S_DIST,
            pbpi_pkg::S_VN, pbpi_pkg::S_SIDE: begin
                r_acc  <= acc_sum;
                r_step <= mac_last ? 2'd0 : r_step + 2'd1;
                if (mac_last) begin
                    case (r_state)
                        pbpi_pkg::S_CR, pbpi_pkg::S_TAN: begin
                            r_t[r_k] <= acc_sum[35:0];
                            r_k      <= nxt(r_k);
                        end
                        pbpi_pkg::S_V: begin
                            r_v[r_k] <= acc_sum[35:0];
                            r_k      <= nxt(r_k);
                        end
                        pbpi_pkg::S_TRI: begin
                            r_pos     <= (acc_sum > 58'sd0) ? CW'(2) : CW'(1);
                            r_ptr     <= r_total;
                        end
                        pbpi_pkg::S_NUM: r_num <= acc_sum[36:0];
                        pbpi_pkg::S_DEN: begin
                            r_den <= acc_sum[35:0];
                            r_k   <= '0;
                            if (clamp_a) begin
                                r_c <= r_pi;
                            end else if (clamp_b) begin
                                r_c <= r_pj;
                            end
                        end
                        pbpi_pkg::S_X: begin
                            r_xneg <= acc_sum[57];
                            r_rem  <= n_mag[pbpi_pkg::REM_W-1:0];
                            r_dsh  <= pbpi_pkg::REM_W'({r_den, 1'b0}) << (pbpi_pkg::QUO_W - 1);
                            r_q    <= '0;
                            r_dcnt <= '0;
                        end
                        pbpi_pkg::S_DIST: r_dist <= acc_sum[pbpi_pkg::DIST_W-1:0];
                        pbpi_pkg::S_VN:   r_vneg <= acc_sum < 58'sd0;
                        pbpi_pkg::S_SIDE: begin
                            if (tie_win) begin
                                r_min  <= r_dist;
                                r_best <= j_idx;
                            end
                        end
                        default: r_k <= r_k;
                    endcase
                end
            end
            pbpi_pkg::S_DIV: begin
                r_rem  <= div_ge ? r_rem - r_dsh : r_rem;
                r_q    <= q_fin;
                r_dsh  <= r_dsh >> 1;
                r_dcnt <= r_dcnt + 5'd1;
                if (div_last) begin
                    r_c[r_k] <= c_sum[15:0];
                    r_k      <= nxt(r_k);
                end
            end
            pbpi_pkg::S_CMP: begin
                r_k <= '0;
                if (r_i == CW'(0) || r_dist < r_min) begin
                    r_min  <= r_dist;
                    r_best <= j_idx;
                end
            end
            pbpi_pkg::S_NEXT: begin
                r_step <= '0;
                r_i    <= r_i + CW'(1);
                r_pos  <= r_best;
                r_ptr  <= r_total;
            end
            pbpi_pkg::S_SHW:  r_ptr <= r_ptr - CW'(1);
            pbpi_pkg::S_REMW: r_ptr <= r_ptr + CW'(1);
            pbpi_pkg::S_DONE: begin
                if (!r_ov || m_tready) begin
                    r_o_err    <= r_err;
                    r_o_total  <= total_w[6:0];
                    r_o_placed <= (r_op == pbpi_pkg::OP_INSERT && !r_err) ? pos_w[5:0] : r_idx;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = {3'b000, r_o_total, r_o_placed};
    assign m_tuser  = r_o_err;

`include "polygon_boundary_point_insert_defines.svh"

    `PBPI_ASSERT_NOW(a_total_range, i_clk, i_rst_n, 1'b1, 16'(r_total) <= 16'(pbpi_pkg::MAX_POINTS), "point total beyond store depth")
    `PBPI_ASSERT_NOW(a_idle_no_write, i_clk, i_rst_n, r_state == pbpi_pkg::S_IDLE, !mem_we, "memory written while idle")
    `PBPI_ASSERT_NEXT(a_remove_count, i_clk, i_rst_n, r_state == pbpi_pkg::S_REM && !(r_ptr + CW'(1) < r_total), r_total == $past(r_total) - CW'(1), "remove did not drop the total")

endmodule
